FILE: design/square_matrix_multiply_macros.svh
// ---------------------------------------------------------------------------
// Square matrix multiply assertion macros
// Concurrent checks clocked on clock and held off during reset.
// ---------------------------------------------------------------------------
`ifndef SQUARE_MATRIX_MULTIPLY_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_MACROS_SVH

`ifndef ASSERT_OFF
`define SMM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("square_matrix_multiply: check failed");
`define SMM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("square_matrix_multiply: check failed");
`define SMM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("square_matrix_multiply: check failed");
`else
`define SMM_ASSERT(label, prop)
`define SMM_ASSERT_IMPL(label, ante, cons)
`define SMM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: design/smm_pkg.sv
// ---------------------------------------------------------------------------
// Square matrix multiply package
// Field widths, operation codes, defaults and the command word type.
// ---------------------------------------------------------------------------
package smm_pkg;

   localparam int MAX_SIZE_DEFAULT      = 32;
   localparam int ELEMENT_WIDTH_DEFAULT = 16;
   localparam int RESULT_LIMIT          = 32;
   localparam int QUEUE_DEPTH           = 4;

   localparam int OP_W     = 2;
   localparam int INDEX_W  = 5;
   localparam int VALUE_W  = 16;
   localparam int SIZE_W   = 6;
   localparam int RESULT_W = 32;

   localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

   localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RESET = 6'd32;

   typedef struct packed {
      logic [OP_W-1:0]    kind;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      logic [VALUE_W-1:0] value;
      logic [SIZE_W-1:0]  size;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

FILE: design/smm_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module smm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/smm_front.sv
// ---------------------------------------------------------------------------
// Square matrix multiply front end
// Holds the size register, takes request words and queues the useful ones.
// ---------------------------------------------------------------------------
module smm_front import smm_pkg::*; #(
   parameter int MAX_SIZE = MAX_SIZE_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OP_W-1:0]           req_operation,
   input  logic [INDEX_W-1:0]        req_row_index,
   input  logic [INDEX_W-1:0]        req_col_index,
   input  logic signed [VALUE_W-1:0] req_element_value,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [SIZE_W-1:0]         csr_active_size,
   input  logic                      queue_full,
   output logic                      push,
   output cmd_type                   push_cmd
);

   localparam int SIZE_LIMIT = (MAX_SIZE < RESULT_LIMIT) ? MAX_SIZE : RESULT_LIMIT;
   localparam int RANGE_W    = 8;

   logic [SIZE_W-1:0] active_size_ff;
   logic [SIZE_W-1:0] active_size_in;
   logic [SIZE_W-1:0] eff_size;
   logic              in_range;
   logic              keep;

   always_comb begin
      active_size_in = active_size_ff;
      if (csr_valid && csr_ready) begin
         active_size_in = csr_active_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_size_ff <= ACTIVE_SIZE_RESET;
      end else begin
         active_size_ff <= active_size_in;
      end
   end

   // clamp the register to the usable size
   always_comb begin
      if (active_size_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (active_size_ff > SIZE_W'(SIZE_LIMIT)) begin
         eff_size = SIZE_W'(SIZE_LIMIT);
      end else begin
         eff_size = active_size_ff;
      end
   end

   assign in_range = (RANGE_W'(req_row_index) < RANGE_W'(MAX_SIZE)) &&
                     (RANGE_W'(req_col_index) < RANGE_W'(MAX_SIZE));

   always_comb begin
      case (req_operation)
         OP_LOAD_A, OP_LOAD_B: keep = in_range;
         OP_COMPUTE:           keep = SIZE_W'(req_row_index) < eff_size;
         default:              keep = 1'b0;
      endcase
   end

   // drop words that do nothing
   assign csr_ready      = 1'b1;
   assign req_ready      = !queue_full;
   assign push           = req_valid && req_ready && keep;
   assign push_cmd.kind  = req_operation;
   assign push_cmd.row   = req_row_index;
   assign push_cmd.col   = req_col_index;
   assign push_cmd.value = req_element_value;
   assign push_cmd.size  = eff_size;

endmodule

FILE: design/smm_queue.sv
// ---------------------------------------------------------------------------
// Square matrix multiply command queue
// Small FIFO of command words between the front end and the back end.
// ---------------------------------------------------------------------------
`include "square_matrix_multiply_macros.svh"

module smm_queue import smm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  cmd_type        push_cmd,
   output logic           full,
   input  logic           pop,
   output queue_head_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   cmd_type          slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.cmd   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `SMM_ASSERT(a_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH))
   `SMM_ASSERT_IMPL(a_pop_nonempty, pop, count_ff != '0)

endmodule

FILE: design/smm_back.sv
// ---------------------------------------------------------------------------
// Square matrix multiply back end
// Writes loads into the A and B stores and runs the multiply-accumulate
// pipeline for compute words: issue, read, multiply, accumulate, result.
// ---------------------------------------------------------------------------
`include "square_matrix_multiply_macros.svh"

module smm_back import smm_pkg::*; #(
   parameter int MAX_SIZE      = MAX_SIZE_DEFAULT,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  queue_head_type             head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [INDEX_W-1:0]         rsp_out_row,
   output logic [INDEX_W-1:0]         rsp_out_col,
   output logic signed [RESULT_W-1:0] rsp_product_value,
   output logic                       rsp_last
);

   localparam int IDX_W  = $clog2(MAX_SIZE);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;

   typedef struct packed {
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      logic               first_k;
      logic               last_k;
      logic               last_col;
   } tag_type;

   logic                     busy_ff, busy_in;
   logic [INDEX_W-1:0]       row_ff, row_in;
   logic [SIZE_W-1:0]        size_ff, size_in;
   logic [INDEX_W-1:0]       j_ff, j_in;
   logic [INDEX_W-1:0]       k_ff, k_in;
   logic                     last_k;
   logic                     last_col;
   logic                     advance;
   logic                     start;

   logic                     s1_valid_ff, s1_valid_in;
   tag_type                  s1_tag_ff, s1_tag_in;
   logic                     s2_valid_ff, s2_valid_in;
   tag_type                  s2_tag_ff;
   logic [RESULT_W-1:0]      prod_ff;
   logic [RESULT_W-1:0]      acc_ff, acc_in;
   logic [RESULT_W-1:0]      sum;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]       rsp_row_ff, rsp_col_ff;
   logic [RESULT_W-1:0]      rsp_value_ff;
   logic                     rsp_last_ff;
   logic                     emit;

   logic                     a_wr_en, b_wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [ELEMENT_WIDTH-1:0] wr_data;
   logic [ADDR_W-1:0]        a_rd_addr, b_rd_addr;
   logic [ELEMENT_WIDTH-1:0] a_rd_data, b_rd_data;
   logic [RESULT_W-1:0]      a_ext, b_ext;

   // hold the whole pipeline while a finished dot product cannot leave
   assign advance  = !(s2_valid_ff && s2_tag_ff.last_k && rsp_valid_ff && !rsp_ready);
   assign last_k   = SIZE_W'(k_ff) == size_ff - SIZE_W'(1);
   assign last_col = SIZE_W'(j_ff) == size_ff - SIZE_W'(1);
   assign pop      = head.valid && !busy_ff;
   assign start    = pop && (head.cmd.kind == OP_COMPUTE);

   // loads
   assign a_wr_en = pop && (head.cmd.kind == OP_LOAD_A);
   assign b_wr_en = pop && (head.cmd.kind == OP_LOAD_B);
   assign wr_addr = {IDX_W'(head.cmd.row), IDX_W'(head.cmd.col)};
   assign wr_data = ELEMENT_WIDTH'($signed(head.cmd.value));

   assign a_rd_addr = {IDX_W'(row_ff), IDX_W'(k_ff)};
   assign b_rd_addr = {IDX_W'(k_ff), IDX_W'(j_ff)};

   smm_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (DEPTH)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (advance),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   smm_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (DEPTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (advance),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // issue counters: k runs inside j
   always_comb begin
      busy_in = busy_ff;
      row_in  = row_ff;
      size_in = size_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      if (start) begin
         busy_in = 1'b1;
         row_in  = head.cmd.row;
         size_in = head.cmd.size;
         j_in    = '0;
         k_in    = '0;
      end else if (busy_ff && advance) begin
         if (last_k) begin
            k_in = '0;
            j_in = j_ff + INDEX_W'(1);
            if (last_col) begin
               busy_in = 1'b0;
            end
         end else begin
            k_in = k_ff + INDEX_W'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in        = s1_valid_ff;
      s1_tag_in          = s1_tag_ff;
      s2_valid_in        = s2_valid_ff;
      if (advance) begin
         s1_valid_in        = busy_ff;
         s1_tag_in.row      = row_ff;
         s1_tag_in.col      = j_ff;
         s1_tag_in.first_k  = k_ff == '0;
         s1_tag_in.last_k   = last_k;
         s1_tag_in.last_col = last_col;
         s2_valid_in        = s1_valid_ff;
      end
   end

   assign a_ext = RESULT_W'($signed(a_rd_data));
   assign b_ext = RESULT_W'($signed(b_rd_data));
   assign sum   = (s2_tag_ff.first_k ? '0 : acc_ff) + prod_ff;
   assign emit  = advance && s2_valid_ff && s2_tag_ff.last_k;

   always_comb begin
      acc_in = acc_ff;
      if (advance && s2_valid_ff) begin
         acc_in = sum;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      size_ff   <= size_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      s1_tag_ff <= s1_tag_in;
      acc_ff    <= acc_in;
      if (advance) begin
         s2_tag_ff <= s1_tag_ff;
         prod_ff   <= a_ext * b_ext;
      end
      if (emit) begin
         rsp_row_ff   <= s2_tag_ff.row;
         rsp_col_ff   <= s2_tag_ff.col;
         rsp_value_ff <= sum;
         rsp_last_ff  <= s2_tag_ff.last_col;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_last          = rsp_last_ff;

   `SMM_ASSERT_IMPL(a_counters_in_size, busy_ff,
      (size_ff != '0) && (SIZE_W'(k_ff) < size_ff) && (SIZE_W'(j_ff) < size_ff))
   `SMM_ASSERT_NEXT(a_stall_holds_tail, s2_valid_ff && !advance,
      s2_valid_ff && $stable(s2_tag_ff) && $stable(prod_ff))
   `SMM_ASSERT_NEXT(a_start_clears_counters, start,
      busy_ff && (j_ff == '0) && (k_ff == '0))

endmodule

FILE: design/square_matrix_multiply.sv
// ---------------------------------------------------------------------------
// Square matrix multiply
// C = A x B on signed integer elements, one result row per compute word.
//
//   channel  dir  ports                                     handshake
//   req      in   operation, row_index, col_index,          req_valid/req_ready
//                 element_value
//   rsp      out  out_row, out_col, product_value, last     rsp_valid/rsp_ready
//   csr      in   active_size                               csr_valid/csr_ready
//
// A load word is written into its element store when the back end pops it.
// A compute word for size n holds the back end for n*n multiply-accumulates,
// one per cycle unless rsp stalls, set by the single read port of each
// element store. Reset clears control only; the element stores hold no value
// until written. A stalled rsp holds the MAC pipeline; req stalls only when
// the queue fills.
// ---------------------------------------------------------------------------
module square_matrix_multiply import smm_pkg::*; #(
   parameter int MAX_SIZE      = MAX_SIZE_DEFAULT,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OP_W-1:0]            req_operation,
   input  logic [INDEX_W-1:0]         req_row_index,
   input  logic [INDEX_W-1:0]         req_col_index,
   input  logic signed [VALUE_W-1:0]  req_element_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [INDEX_W-1:0]         rsp_out_row,
   output logic [INDEX_W-1:0]         rsp_out_col,
   output logic signed [RESULT_W-1:0] rsp_product_value,
   output logic                       rsp_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [SIZE_W-1:0]          csr_active_size
);

   logic           push;
   cmd_type        push_cmd;
   logic           queue_full;
   logic           pop;
   queue_head_type head;

   smm_front #(
      .MAX_SIZE (MAX_SIZE)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_active_size   (csr_active_size),
      .queue_full        (queue_full),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   smm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head     (head)
   );

   smm_back #(
      .MAX_SIZE      (MAX_SIZE),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last          (rsp_last)
   );

endmodule
